[hdl/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms; clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define SIT_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define SIT_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[hdl/sit_pkg.sv]
// ----------------------------------------------------------------------------
// sit_pkg
// Shared constants and types of the segment intersection test.
// ----------------------------------------------------------------------------
package sit_pkg;

	// default coordinate width
	localparam int COORD_BITS_DEF = 16;

	// result tdata: one flag padded to a byte
	localparam int OUT_TDATA_W = 8;

	// per-stage load enables of the product unit
	typedef struct packed {
		logic s2;
		logic s3;
	} sit_adv_t;

endpackage

[hdl/sit_xprod.sv]
// ----------------------------------------------------------------------------
// sit_xprod
// Two registered signed products, then their registered difference:
// r = a0*b0 - a1*b1. Serves both cross and dot products.
// ----------------------------------------------------------------------------
module sit_xprod #(
	parameter int W = sit_pkg::COORD_BITS_DEF + 1
) (
	input  logic                   clk,
	input  sit_pkg::sit_adv_t      adv,
	input  logic signed [W-1:0]    a0,
	input  logic signed [W-1:0]    b0,
	input  logic signed [W-1:0]    a1,
	input  logic signed [W-1:0]    b1,
	output logic signed [2*W:0]    r_s3
);
	import sit_pkg::*;

	logic signed [2*W-1:0] p0_s2;
	logic signed [2*W-1:0] p1_s2;

	always_ff @(posedge clk) begin
		if (adv.s2) begin
			p0_s2 <= a0 * b0;
			p1_s2 <= a1 * b1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv.s3) begin
			r_s3 <= (2*W+1)'(p0_s2) - (2*W+1)'(p1_s2);
		end
	end

endmodule

[hdl/segment_intersection_test_core.sv]
// ----------------------------------------------------------------------------
// segment_intersection_test_core
// Exact closed-segment intersection test on integer coordinates, pipelined.
// ----------------------------------------------------------------------------
//
// channel  dir  handshake           payload
// -------  ---  ------------------  ------------------------------------------
// s_*      in   s_tvalid/s_tready   s_tdata: two segments, 8 coords
// m_*      out  m_tvalid/m_tready   m_tdata: segments_meet flag
//
// Stages: diff, multiply, combine, decide; one item per cycle while m_tready
// holds the output open. The 9 product units each hold one item per stage.
// Reset clears the stage valid bits only; payload registers are not reset.
// Each stage holds while the stage after it is full and stalled, so a stall
// on m_tready backs up stage by stage and empty stages still fill.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module segment_intersection_test_core #(
	parameter int COORD_BITS = sit_pkg::COORD_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// from bit 0 up: seg1_start_x, seg1_start_y, seg1_end_x, seg1_end_y,
	// seg2_start_x, seg2_start_y, seg2_end_x, seg2_end_y (COORD_BITS each)
	input  logic [8*COORD_BITS-1:0]           s_tdata,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// from bit 0 up: segments_meet, then zero padding
	output logic [sit_pkg::OUT_TDATA_W-1:0]   m_tdata
);
	import sit_pkg::*;

	localparam int C  = COORD_BITS;
	localparam int DW = C + 1;        // coordinate difference
	localparam int PW = 2 * DW + 1;   // cross / dot result
	localparam int NX = 9;            // product units

	// product unit slots
	localparam int X_DET  = 0;  // cross(ba, qp) = -det
	localparam int X_DETX = 1;  // cross(ap, qp) = detx
	localparam int X_DETY = 2;  // cross(ap, ba) = dety
	localparam int X_CR2  = 3;  // cross(aq, ba)
	localparam int X_CR4  = 4;  // cross(bp, qp)
	localparam int X_D1   = 5;  // dot(ap, bp)
	localparam int X_D2   = 6;  // dot(aq, bq)
	localparam int X_D3   = 7;  // dot(ap, aq)
	localparam int X_D4   = 8;  // dot(bp, bq)

	// --- stage control ----------------------------------------------------
	logic vld_s1, vld_s2, vld_s3, vld_s4;
	logic en1, en2, en3, en4;
	sit_adv_t adv;

	// a stage loads when it is empty or its content moves on
	assign en4 = !vld_s4 || m_tready;
	assign en3 = !vld_s3 || en4;
	assign en2 = !vld_s2 || en3;
	assign en1 = !vld_s1 || en2;
	assign adv = '{s2: en2, s3: en3};
	assign s_tready = en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else begin
			if (en1) vld_s1 <= s_tvalid;
			if (en2) vld_s2 <= vld_s1;
			if (en3) vld_s3 <= vld_s2;
			if (en4) vld_s4 <= vld_s3;
		end
	end

	// --- unpack: a = seg1 start, b = seg1 end, p = seg2 start, q = seg2 end
	logic signed [C-1:0] ax, ay, bx, by, px, py, qx, qy;
	assign ax = s_tdata[0*C +: C];
	assign ay = s_tdata[1*C +: C];
	assign bx = s_tdata[2*C +: C];
	assign by = s_tdata[3*C +: C];
	assign px = s_tdata[4*C +: C];
	assign py = s_tdata[5*C +: C];
	assign qx = s_tdata[6*C +: C];
	assign qy = s_tdata[7*C +: C];

	// --- s1: differences --------------------------------------------------
	logic signed [DW-1:0] ba_x_s1, ba_y_s1, qp_x_s1, qp_y_s1;
	logic signed [DW-1:0] ap_x_s1, ap_y_s1, aq_x_s1, aq_y_s1;
	logic signed [DW-1:0] bp_x_s1, bp_y_s1, bq_x_s1, bq_y_s1;
	// negated y terms turn each dot product into a difference of products
	logic signed [DW-1:0] pa_y_s1, qa_y_s1, pb_y_s1;

	always_ff @(posedge clk) begin
		if (en1) begin
			ba_x_s1 <= DW'(bx) - DW'(ax);
			ba_y_s1 <= DW'(by) - DW'(ay);
			qp_x_s1 <= DW'(qx) - DW'(px);
			qp_y_s1 <= DW'(qy) - DW'(py);
			ap_x_s1 <= DW'(ax) - DW'(px);
			ap_y_s1 <= DW'(ay) - DW'(py);
			aq_x_s1 <= DW'(ax) - DW'(qx);
			aq_y_s1 <= DW'(ay) - DW'(qy);
			bp_x_s1 <= DW'(bx) - DW'(px);
			bp_y_s1 <= DW'(by) - DW'(py);
			bq_x_s1 <= DW'(bx) - DW'(qx);
			bq_y_s1 <= DW'(by) - DW'(qy);
			pa_y_s1 <= DW'(py) - DW'(ay);
			qa_y_s1 <= DW'(qy) - DW'(ay);
			pb_y_s1 <= DW'(py) - DW'(by);
		end
	end

	// --- s2/s3: products and their sums ------------------------------------
	logic signed [DW-1:0] op_a0 [NX];
	logic signed [DW-1:0] op_b0 [NX];
	logic signed [DW-1:0] op_a1 [NX];
	logic signed [DW-1:0] op_b1 [NX];
	logic signed [PW-1:0] res_s3 [NX];

	// cross(u, v) = ux*vy - uy*vx
	assign op_a0[X_DET]  = ba_x_s1; assign op_b0[X_DET]  = qp_y_s1;
	assign op_a1[X_DET]  = ba_y_s1; assign op_b1[X_DET]  = qp_x_s1;
	assign op_a0[X_DETX] = ap_x_s1; assign op_b0[X_DETX] = qp_y_s1;
	assign op_a1[X_DETX] = ap_y_s1; assign op_b1[X_DETX] = qp_x_s1;
	assign op_a0[X_DETY] = ap_x_s1; assign op_b0[X_DETY] = ba_y_s1;
	assign op_a1[X_DETY] = ap_y_s1; assign op_b1[X_DETY] = ba_x_s1;
	assign op_a0[X_CR2]  = aq_x_s1; assign op_b0[X_CR2]  = ba_y_s1;
	assign op_a1[X_CR2]  = aq_y_s1; assign op_b1[X_CR2]  = ba_x_s1;
	assign op_a0[X_CR4]  = bp_x_s1; assign op_b0[X_CR4]  = qp_y_s1;
	assign op_a1[X_CR4]  = bp_y_s1; assign op_b1[X_CR4]  = qp_x_s1;
	// dot(u, v) = ux*vx - (-uy)*vy
	assign op_a0[X_D1]   = ap_x_s1; assign op_b0[X_D1]   = bp_x_s1;
	assign op_a1[X_D1]   = pa_y_s1; assign op_b1[X_D1]   = bp_y_s1;
	assign op_a0[X_D2]   = aq_x_s1; assign op_b0[X_D2]   = bq_x_s1;
	assign op_a1[X_D2]   = qa_y_s1; assign op_b1[X_D2]   = bq_y_s1;
	assign op_a0[X_D3]   = ap_x_s1; assign op_b0[X_D3]   = aq_x_s1;
	assign op_a1[X_D3]   = pa_y_s1; assign op_b1[X_D3]   = aq_y_s1;
	assign op_a0[X_D4]   = bp_x_s1; assign op_b0[X_D4]   = bq_x_s1;
	assign op_a1[X_D4]   = pb_y_s1; assign op_b1[X_D4]   = bq_y_s1;

	for (genvar i = 0; i < NX; i++) begin : g_xp
		sit_xprod #(.W(DW)) u_xp (
			.clk  (clk),
			.adv  (adv),
			.a0   (op_a0[i]),
			.b0   (op_b0[i]),
			.a1   (op_a1[i]),
			.b1   (op_b1[i]),
			.r_s3 (res_s3[i])
		);
	end

	// --- s4: decide ----------------------------------------------------------
	logic par, on1, on2, on3, on4;
	logic signed [PW:0] sum_x, sum_y;
	logic rat_x, rat_y, meet;
	logic neg_c;

	// endpoint on segment: collinear and dot product not positive
	function automatic logic on_seg(input logic signed [PW-1:0] cr,
	                                input logic signed [PW-1:0] dt);
		return (cr == '0) && (dt[PW-1] || (dt == '0));
	endfunction

	// det = -c; num/det in [0,1]:
	//   det > 0: num >= 0 and num + c <= 0
	//   det < 0: num <= 0 and num + c >= 0
	function automatic logic in_unit(input logic signed [PW-1:0] num,
	                                 input logic signed [PW:0] sum,
	                                 input logic c_neg);
		logic num_le0;
		logic sum_le0;
		num_le0 = num[PW-1] || (num == '0);
		sum_le0 = sum[PW] || (sum == '0);
		return c_neg ? (!num[PW-1] && sum_le0) : (num_le0 && !sum[PW]);
	endfunction

	always_comb begin
		par   = (res_s3[X_DET] == '0);
		neg_c = res_s3[X_DET][PW-1];
		on1   = on_seg(res_s3[X_DETY], res_s3[X_D1]);
		on2   = on_seg(res_s3[X_CR2],  res_s3[X_D2]);
		on3   = on_seg(res_s3[X_DETX], res_s3[X_D3]);
		on4   = on_seg(res_s3[X_CR4],  res_s3[X_D4]);
		sum_x = (PW+1)'(res_s3[X_DETX]) + (PW+1)'(res_s3[X_DET]);
		sum_y = (PW+1)'(res_s3[X_DETY]) + (PW+1)'(res_s3[X_DET]);
		rat_x = in_unit(res_s3[X_DETX], sum_x, neg_c);
		rat_y = in_unit(res_s3[X_DETY], sum_y, neg_c);
		meet  = par ? (on1 || on2 || on3 || on4) : (rat_x && rat_y);
	end

	logic meet_s4;

	always_ff @(posedge clk) begin
		if (en4) begin
			meet_s4 <= meet;
		end
	end

	assign m_tvalid = vld_s4;
	assign m_tdata  = OUT_TDATA_W'(meet_s4);

	// --- assertions -------------------------------------------------------------
	// full pipe under output stall refuses new items
	`SIT_ASSERT_IMP(a_full_stall, vld_s1 && vld_s2 && vld_s3 && vld_s4 && !m_tready, !s_tready, "input taken while pipe full and stalled")
	// with m_tready held high an accepted item passes s1 to s4 and reaches the output
	`SIT_ASSERT_NXT(a_latency, (s_tvalid && s_tready) ##1 m_tready ##1 m_tready ##1 m_tready, m_tvalid, "item missing at output after pipe latency")
	// a held stage keeps its item
	`SIT_ASSERT_NXT(a_hold_s2, vld_s2 && !en3, vld_s2, "stage 2 item dropped during stall")

endmodule
